// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: sv/otv_pkg.sv
// shared types and constants of the order table
// no dependencies
package otv_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned ID_W = 32;
	localparam int unsigned QTY_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_OUT_W = 7;
	localparam int unsigned TOTAL_OUT_W = 22;
	localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX = '1;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [QTY_W-1:0] qty;
		logic [QTY_W-1:0] outq;
	} entry_t;

	// broadcast strobes to every cell
	typedef struct packed {
		logic cmp;
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage

// File: sv/otv_cell.sv
// one table slot: holds an entry, compares its id, loads or takes its upper neighbor
// depends on otv_pkg
module otv_cell import otv_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CNT_W = 7,
	parameter int unsigned IDX_W = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  cell_ctl_t ctl,
	input  logic [ID_W-1:0] cmp_id,
	input  logic [CNT_W-1:0] count,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [IDX_W-1:0] place,
	input  entry_t din,
	input  entry_t nbr,
	output entry_t dout,
	output logic match,
	output logic [QTY_W-1:0] qty_m,
	output logic [QTY_W-1:0] outq_m
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] IDX_P = IDX_W'(IDX);

	entry_t entry_q;
	logic match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			// only occupied slots may match
			match_q <= (IDX_C < count) && (entry_q.id == cmp_id);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && (wr_idx == IDX_P)) begin
			entry_q <= din;
		end else if (ctl.shift && (IDX_P >= place)) begin
			entry_q <= nbr;
		end
	end

	assign dout = entry_q;
	assign match = match_q;
	assign qty_m = match_q ? entry_q.qty : '0;
	assign outq_m = match_q ? entry_q.outq : '0;

endmodule

// File: sv/otv_reduce.sv
// folds the per-cell match flags into found, place and the matched entry's quantities
// depends on otv_pkg; the ids in the table are unique, so at most one flag is set
module otv_reduce import otv_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic match [DEPTH],
	input  logic [QTY_W-1:0] qty_m [DEPTH],
	input  logic [QTY_W-1:0] outq_m [DEPTH],
	output logic found,
	output logic [IDX_W-1:0] place,
	output logic [QTY_W-1:0] del_qty,
	output logic [QTY_W-1:0] del_outq
);

	logic found_c;
	logic [IDX_W-1:0] place_c;
	logic [QTY_W-1:0] qty_c;
	logic [QTY_W-1:0] outq_c;
	logic found_q;
	logic [IDX_W-1:0] place_q;
	logic [QTY_W-1:0] del_qty_q;
	logic [QTY_W-1:0] del_outq_q;

	always_comb begin
		found_c = 1'b0;
		place_c = '0;
		qty_c = '0;
		outq_c = '0;
		for (int k = 0; k < DEPTH; k++) begin
			found_c = found_c | match[k];
			place_c = place_c | (match[k] ? IDX_W'(k) : '0);
			qty_c = qty_c | qty_m[k];
			outq_c = outq_c | outq_m[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found_c;
		end
	end

	always_ff @(posedge clk) begin
		place_q <= place_c;
		del_qty_q <= qty_c;
		del_outq_q <= outq_c;
	end

	assign found = found_q;
	assign place = place_q;
	assign del_qty = del_qty_q;
	assign del_outq = del_outq_q;

endmodule

// File: sv/order_table_with_volume_totals.sv
// top level of the order table: a row of entry cells, a match reducer and the sequencer
// depends on otv_pkg, otv_cell, otv_reduce
//
//  channel | signals                                              | direction
//  in      | in_valid in_ready operation order_id quantity        | into block
//          | outstanding_quantity                                 |
//  out     | out_valid out_ready status entry_count total_volume  | out of block
//          | total_outstanding                                    |
//
// an item is handled in order: the accept edge compares its id in every cell at once,
// the reducer then registers the folded match flags, and the apply step updates the row
// (load at the tail or shift down one place) and the running totals and loads the result.
// a full output register stalls only the update step; a new item is taken while a
// result waits. reset clears the fill count, the totals and the handshake state.
module order_table_with_volume_totals import otv_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic [ID_W-1:0] order_id,
	input  logic [QTY_W-1:0] quantity,
	input  logic [QTY_W-1:0] outstanding_quantity,
	output logic out_valid,
	input  logic out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_OUT_W-1:0] entry_count,
	output logic [TOTAL_OUT_W-1:0] total_volume,
	output logic [TOTAL_OUT_W-1:0] total_outstanding
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned SUM_W = QTY_W + CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RED = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] vol_q;
	logic [SUM_W-1:0] outs_q;
	logic op_q;
	entry_t item_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_OUT_W-1:0] count_out_q;
	logic [TOTAL_OUT_W-1:0] vol_out_q;
	logic [TOTAL_OUT_W-1:0] outs_out_q;

	logic in_acc;
	logic apply;
	cell_ctl_t ctl;
	logic [STATUS_W-1:0] st_c;
	logic [CNT_W-1:0] count_c;
	logic [SUM_W-1:0] vol_c;
	logic [SUM_W-1:0] outs_c;
	logic [31:0] count_ext;
	logic [31:0] vol_ext;
	logic [31:0] outs_ext;

	entry_t cell_out [TABLE_DEPTH];
	entry_t cell_nbr [TABLE_DEPTH];
	logic cell_match [TABLE_DEPTH];
	logic [QTY_W-1:0] cell_qty [TABLE_DEPTH];
	logic [QTY_W-1:0] cell_outq [TABLE_DEPTH];

	logic found;
	logic [IDX_W-1:0] place;
	logic [QTY_W-1:0] del_qty;
	logic [QTY_W-1:0] del_outq;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign apply = (state_q == S_APPLY) && (!out_valid_q || out_ready);

	always_comb begin
		st_c = ST_DONE;
		count_c = count_q;
		vol_c = vol_q;
		outs_c = outs_q;
		ctl.cmp = in_acc;
		ctl.wr = 1'b0;
		ctl.shift = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (found) begin
					st_c = ST_DUPLICATE;
				end else if (count_q == DEPTH_C) begin
					st_c = ST_FULL;
				end else begin
					ctl.wr = apply;
					count_c = count_q + CNT_W'(1);
					vol_c = vol_q + SUM_W'(item_q.qty);
					outs_c = outs_q + SUM_W'(item_q.outq);
				end
			end
			OP_DELETE: begin
				if (!found) begin
					st_c = ST_NOT_FOUND;
				end else begin
					ctl.shift = apply;
					count_c = count_q - CNT_W'(1);
					vol_c = vol_q - SUM_W'(del_qty);
					outs_c = outs_q - SUM_W'(del_outq);
				end
			end
			default: begin
				st_c = ST_DONE;
			end
		endcase
	end

	assign count_ext = 32'(count_c);
	assign vol_ext = 32'(vol_c);
	assign outs_ext = 32'(outs_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			vol_q <= '0;
			outs_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_RED;
				end
				S_RED: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (apply) begin
				count_q <= count_c;
				vol_q <= vol_c;
				outs_q <= outs_c;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= operation;
			item_q.id <= order_id;
			item_q.qty <= quantity;
			item_q.outq <= outstanding_quantity;
		end
		if (apply) begin
			status_q <= st_c;
			// wide tables and large totals saturate at the field maximum
			count_out_q <= (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX
				: count_ext[COUNT_OUT_W-1:0];
			vol_out_q <= (vol_ext > 32'(TOTAL_MAX)) ? TOTAL_MAX : vol_ext[TOTAL_OUT_W-1:0];
			outs_out_q <= (outs_ext > 32'(TOTAL_MAX)) ? TOTAL_MAX : outs_ext[TOTAL_OUT_W-1:0];
		end
	end

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		if (k < TABLE_DEPTH - 1) begin : g_mid
			assign cell_nbr[k] = cell_out[k+1];
		end else begin : g_last
			assign cell_nbr[k] = '0;
		end
		otv_cell #(
			.IDX(k),
			.CNT_W(CNT_W),
			.IDX_W(IDX_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.cmp_id(order_id),
			.count(count_q),
			.wr_idx(count_q[IDX_W-1:0]),
			.place(place),
			.din(item_q),
			.nbr(cell_nbr[k]),
			.dout(cell_out[k]),
			.match(cell_match[k]),
			.qty_m(cell_qty[k]),
			.outq_m(cell_outq[k])
		);
	end

	otv_reduce #(
		.DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.match(cell_match),
		.qty_m(cell_qty),
		.outq_m(cell_outq),
		.found(found),
		.place(place),
		.del_qty(del_qty),
		.del_outq(del_outq)
	);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign entry_count = count_out_q;
	assign total_volume = vol_out_q;
	assign total_outstanding = outs_out_q;

endmodule

// File: sv/otv_checker.sv
// port-level checks of the order table, bound to the top level
// depends on otv_pkg and assert_macros.svh
`include "assert_macros.svh"

module otv_checker import otv_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [COUNT_OUT_W-1:0] entry_count,
	input logic [TOTAL_OUT_W-1:0] total_volume,
	input logic [TOTAL_OUT_W-1:0] total_outstanding
);

	localparam logic [COUNT_OUT_W-1:0] FULL_CNT = (TABLE_DEPTH > 32'(COUNT_MAX)) ? COUNT_MAX
		: COUNT_OUT_W'(TABLE_DEPTH);

	// a waiting result holds
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count))

	// the block is busy right after it takes an item
	`AST_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

	// a full refusal reports a full table
	`AST_IMPLY(a_full_count, clk, arst_n, out_valid && (status == ST_FULL), entry_count == FULL_CNT)

	// an empty table has no volume
	`AST_IMPLY(a_empty_totals, clk, arst_n, out_valid && (entry_count == '0), (total_volume == '0) && (total_outstanding == '0))

endmodule

bind order_table_with_volume_totals otv_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_otv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.entry_count(entry_count),
	.total_volume(total_volume),
	.total_outstanding(total_outstanding)
);

// File: tb/order_table_with_volume_totals_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the order table with volume totals
// depends on otv_pkg and order_table_with_volume_totals
module order_table_with_volume_totals_tb;
	import otv_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_OUT_W-1:0] count;
		logic [TOTAL_OUT_W-1:0] volume;
		logic [TOTAL_OUT_W-1:0] outstanding;
	} order_totals_t;

	class order_table_scoreboard;
		logic [ID_W-1:0] held_ids[TABLE_DEPTH_DEF];
		logic [QTY_W-1:0] held_qty[TABLE_DEPTH_DEF];
		logic [QTY_W-1:0] held_outq[TABLE_DEPTH_DEF];
		int unsigned held_count;
		order_totals_t expected_totals[$];
		int unsigned mismatches;

		function new();
			held_count = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_totals.size();
		endfunction

		function int locate(logic [ID_W-1:0] id);
			for (int k = 0; k < held_count; k++) begin
				if (held_ids[k] == id)
					return k;
			end
			return -1;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		// update the held table for one accepted item and queue its totals
		function void apply_order(logic op, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty,
				logic [QTY_W-1:0] outq);
			int place;
			int unsigned vol;
			int unsigned outs;
			order_totals_t want;
			place = locate(id);
			if (op == OP_ADD) begin
				if (place >= 0) begin
					want.status = ST_DUPLICATE;
				end else if (held_count >= TABLE_DEPTH_DEF) begin
					want.status = ST_FULL;
				end else begin
					held_ids[held_count] = id;
					held_qty[held_count] = qty;
					held_outq[held_count] = outq;
					held_count++;
					want.status = ST_DONE;
				end
			end else begin
				if (place < 0) begin
					want.status = ST_NOT_FOUND;
				end else begin
					// later entries move down one place, arrival order kept
					for (int k = place; k + 1 < held_count; k++) begin
						held_ids[k] = held_ids[k + 1];
						held_qty[k] = held_qty[k + 1];
						held_outq[k] = held_outq[k + 1];
					end
					held_count--;
					want.status = ST_DONE;
				end
			end
			vol = 0;
			outs = 0;
			for (int k = 0; k < held_count; k++) begin
				vol += held_qty[k];
				outs += held_outq[k];
			end
			want.count = (held_count > COUNT_MAX) ? COUNT_MAX
				: held_count[COUNT_OUT_W-1:0];
			want.volume = (vol > TOTAL_MAX) ? TOTAL_MAX : vol[TOTAL_OUT_W-1:0];
			want.outstanding = (outs > TOTAL_MAX) ? TOTAL_MAX : outs[TOTAL_OUT_W-1:0];
			expected_totals.push_back(want);
		endfunction

		task check_totals(order_totals_t got);
			order_totals_t want;
			if (expected_totals.size() == 0) begin
				report_mismatch("result with no item pending");
			end else begin
				want = expected_totals.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got.status, want.status));
				if (got.count !== want.count)
					report_mismatch($sformatf("entry_count got %0d want %0d",
						got.count, want.count));
				if (got.volume !== want.volume)
					report_mismatch($sformatf("total_volume got %0d want %0d",
						got.volume, want.volume));
				if (got.outstanding !== want.outstanding)
					report_mismatch($sformatf("total_outstanding got %0d want %0d",
						got.outstanding, want.outstanding));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [ID_W-1:0] order_id;
	logic [QTY_W-1:0] quantity;
	logic [QTY_W-1:0] outstanding_quantity;
	logic out_valid;
	logic out_ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic [TOTAL_OUT_W-1:0] total_volume;
	logic [TOTAL_OUT_W-1:0] total_outstanding;

	order_table_scoreboard sb;
	bit steady = 1'b0;
	int unsigned stall_cycles = 0;

	order_table_with_volume_totals dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.order_id(order_id),
		.quantity(quantity),
		.outstanding_quantity(outstanding_quantity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.total_volume(total_volume),
		.total_outstanding(total_outstanding)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
	end

	// results are checked before the item of the same edge is noted
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_totals({status, entry_count, total_volume, total_outstanding});
		if (in_valid && in_ready)
			sb.apply_order(operation, order_id, quantity, outstanding_quantity);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("order_table_with_volume_totals regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_order(logic op, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty,
			logic [QTY_W-1:0] outq);
		while (!steady && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		order_id <= id;
		quantity <= qty;
		outstanding_quantity <= outq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic [QTY_W-1:0] pick_qty();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return QTY_W'($urandom);
		endcase
	endfunction

	// held ids are picked often for deletes and sometimes for adds, so that deletes hit and adds collide
	task automatic random_order(int add_pct, bit max_qty);
		logic op;
		logic [ID_W-1:0] id;
		int pick;
		op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DELETE;
		pick = $urandom_range(0, 99);
		if (sb.held_count > 0 && pick < ((op == OP_ADD) ? 8 : 75))
			id = sb.held_ids[$urandom_range(0, sb.held_count - 1)];
		else if (pick >= 92)
			id = $urandom_range(0, 7);
		else
			id = $urandom;
		send_order(op, id, max_qty ? '1 : pick_qty(), max_qty ? '1 : pick_qty());
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		order_id = '0;
		quantity = '0;
		outstanding_quantity = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, id and quantity extremes, duplicates, delete positions
		send_order(OP_DELETE, 32'd5, 16'h1234, 16'h4321);
		send_order(OP_ADD, 32'h0000_0000, 16'h0000, 16'h0000);
		send_order(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_order(OP_ADD, 32'h0000_0000, 16'h00FF, 16'h0F0F);
		send_order(OP_ADD, 32'hA5A5_A5A5, 16'h1234, 16'hFFFF);
		send_order(OP_ADD, 32'h5A5A_5A5A, 16'hFFFF, 16'h0000);
		send_order(OP_DELETE, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
		send_order(OP_DELETE, 32'd7, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'h5A5A_5A5A, 16'h5555, 16'hAAAA);
		send_order(OP_ADD, 32'h0000_0001, 16'h0001, 16'h8000);
		send_order(OP_ADD, 32'h8000_0000, 16'h8000, 16'h0001);
		send_order(OP_ADD, 32'h0000_0002, 16'hAAAA, 16'h5555);
		send_order(OP_DELETE, 32'h8000_0000, 16'h0000, 16'h0000);
		send_order(OP_ADD, 32'h8000_0000, 16'h7FFF, 16'h7FFF);
		send_order(OP_DELETE, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'hA5A5_A5A5, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'h0000_0001, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'h0000_0002, 16'h0000, 16'h0000);
		send_order(OP_DELETE, 32'h8000_0000, 16'h0000, 16'h0000);
		wait_drained();

		// fill past full then drain, three rounds; one fill at peak quantities
		for (int round = 0; round < 3; round++) begin
			steady = (round == 1);
			repeat (85) random_order(95, round == 1);
			steady = 1'b0;
			wait_drained();
			repeat (75) random_order(15, 1'b0);
		end
		repeat (30) random_order(50, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch("items left without a result");
		if (sb.mismatches == 0)
			$display("order_table_with_volume_totals regression: pass");
		else
			$display("order_table_with_volume_totals regression: fail");
		$finish;
	end

endmodule

// File: order_table_with_volume_totals.f
+incdir+sv
sv/otv_pkg.sv
sv/otv_cell.sv
sv/otv_reduce.sv
sv/order_table_with_volume_totals.sv
sv/otv_checker.sv
tb/order_table_with_volume_totals_tb.sv
